@@ hw/rtl/fstp_pkg.sv @@
package fstp_pkg;

  localparam int unsigned MaxTasks = 16;
  localparam int unsigned IdxW     = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;

  localparam int unsigned TaskW    = 4;
  localparam int unsigned TicksW   = 32;
  localparam int unsigned RtW      = 64;
  localparam int unsigned OpW      = 2;

  // s_axis tdata: task_id, elapsed_ticks, padded to bytes
  localparam int unsigned InDataW  = ((TaskW + TicksW + 7) / 8) * 8;
  // m_axis tdata: picked_task, watermark_out, padded to bytes
  localparam int unsigned OutDataW = ((TaskW + RtW + 7) / 8) * 8;

  localparam logic [OpW-1:0] OpTick    = 2'd0;
  localparam logic [OpW-1:0] OpEnqueue = 2'd1;
  localparam logic [OpW-1:0] OpDequeue = 2'd2;
  localparam logic [OpW-1:0] OpPick    = 2'd3;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
    logic [RtW-1:0]  data;
  } ram_wr_t;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
  } ram_rd_t;

endpackage

@@ hw/rtl/fstp_ram.sv @@
module fstp_ram (
  input  logic                      clk_i,
  input  fstp_pkg::ram_wr_t         wr_i,
  input  fstp_pkg::ram_rd_t         rd_i,
  output logic [fstp_pkg::RtW-1:0]  rd_data_o
);

  logic [fstp_pkg::RtW-1:0] mem [fstp_pkg::MaxTasks];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_o <= mem[rd_i.addr];
    end
  end

endmodule

@@ hw/rtl/fair_share_task_picker.sv @@
// Fair-share task picker: a table of task slots, each with a valid bit and a
// 64-bit virtual runtime kept in a single-port-read RAM, plus a watermark.
// Input channel s_axis: one beat is one command (tick, enqueue, dequeue,
// pick). Output channel m_axis: exactly one result beat per command, in order.
// Each command passes through its states in order: tick StExec, StTickWb
// (skipped when the slot is empty), StDone; enqueue/dequeue StExec, StDone;
// pick StScan over all MaxTasks slots, StDone. The block works on one command
// at a time; the next command is taken the cycle after the current one has
// moved its result into the output register. Pick throughput is set by the
// RAM read port: the scan reads one slot per cycle in ring order from the slot
// named by the command's task_id.
// Tick is a read, a 64-bit add and a write-back through the same RAM.
// Reset clears the valid bits, the watermark and the output valid flag; the
// runtime RAM is not cleared (a slot is always written by the enqueue that
// makes it valid). When m_axis stalls, the result is held in the output
// register; one further command can be accepted and processed, and it then
// waits with its result until the output register is free.
module fair_share_task_picker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [3:0] task_id, [35:4] elapsed_ticks, [39:36] zero
  input  logic [fstp_pkg::InDataW-1:0]    s_axis_tdata_i,
  // [1:0] opcode
  input  logic [fstp_pkg::OpW-1:0]        s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [3:0] picked_task, [67:4] watermark_out, [71:68] zero
  output logic [fstp_pkg::OutDataW-1:0]   m_axis_tdata_o,
  // [0] picked_valid
  output logic                            m_axis_tuser_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StExec   = 3'd1;
  localparam logic [2:0] StTickWb = 3'd2;
  localparam logic [2:0] StScan   = 3'd3;
  localparam logic [2:0] StDone   = 3'd4;

  localparam logic [fstp_pkg::IdxW-1:0] LastIdx = fstp_pkg::IdxW'(fstp_pkg::MaxTasks - 1);

  logic [2:0]                     state_q, state_d;
  logic [fstp_pkg::MaxTasks-1:0]  valid_q, valid_d;
  logic [fstp_pkg::RtW-1:0]       wm_q, wm_d;
  logic                           out_vld_q, out_vld_d;

  logic [fstp_pkg::OpW-1:0]       op_q;
  logic [fstp_pkg::IdxW-1:0]      slot_q;
  logic                           in_range_q;
  logic [fstp_pkg::TicksW-1:0]    ticks_q;
  logic [fstp_pkg::RtW-1:0]       sum_q;
  logic [fstp_pkg::IdxW-1:0]      rd_idx_q;
  logic [fstp_pkg::IdxW-1:0]      cnt_q;
  logic                           found_q;
  logic [fstp_pkg::RtW-1:0]       least_q;
  logic [fstp_pkg::IdxW-1:0]      best_q;

  logic [fstp_pkg::TaskW-1:0]     out_task_q;
  logic                           out_flag_q;
  logic [fstp_pkg::RtW-1:0]       out_wm_q;

  logic                           accept;
  logic                           load_out;
  logic [fstp_pkg::TaskW-1:0]     in_task;
  logic                           in_range;
  logic [fstp_pkg::IdxW-1:0]      start_idx;
  logic [fstp_pkg::IdxW-1:0]      next_idx;
  logic                           take;
  logic                           scan_end;
  fstp_pkg::ram_wr_t              ram_wr;
  fstp_pkg::ram_rd_t              ram_rd;
  logic [fstp_pkg::RtW-1:0]       rd_data;

  assign in_task   = s_axis_tdata_i[fstp_pkg::TaskW-1:0];
  assign in_range  = 32'(in_task) < fstp_pkg::MaxTasks;
  assign start_idx = in_range ? fstp_pkg::IdxW'(in_task) : '0;
  assign next_idx  = (rd_idx_q == LastIdx) ? '0 : rd_idx_q + fstp_pkg::IdxW'(1);

  assign s_axis_tready_o = (state_q == StIdle);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign load_out        = (state_q == StDone) && (!out_vld_q || m_axis_tready_i);
  assign scan_end        = (cnt_q == LastIdx);

  // slot under compare this cycle; first valid slot wins ties
  assign take = (state_q == StScan) && valid_q[rd_idx_q] && (!found_q || rd_data < least_q);

  // read of the start slot goes out with the accept, so its data is ready in
  // StExec/StScan; all writes finish before the next accept, so no forwarding
  assign ram_rd.en   = accept || (state_q == StScan);
  assign ram_rd.addr = accept ? start_idx : next_idx;

  always_comb begin
    ram_wr.en   = 1'b0;
    ram_wr.addr = slot_q;
    ram_wr.data = wm_q;
    if (state_q == StExec && op_q == fstp_pkg::OpEnqueue && in_range_q) begin
      ram_wr.en = 1'b1;
    end else if (state_q == StTickWb) begin
      ram_wr.en   = 1'b1;
      ram_wr.data = sum_q;
    end
  end

  fstp_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (ram_wr),
    .rd_i      (ram_rd),
    .rd_data_o (rd_data)
  );

  always_comb begin
    state_d   = state_q;
    valid_d   = valid_q;
    wm_d      = wm_q;
    out_vld_d = out_vld_q;
    if (out_vld_q && m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = (s_axis_tuser_i == fstp_pkg::OpPick) ? StScan : StExec;
        end
      end
      StExec: begin
        state_d = StDone;
        case (op_q)
          fstp_pkg::OpTick: begin
            if (in_range_q && valid_q[slot_q]) begin
              state_d = StTickWb;
            end
          end
          fstp_pkg::OpEnqueue: begin
            if (in_range_q) begin
              valid_d[slot_q] = 1'b1;
            end
          end
          fstp_pkg::OpDequeue: begin
            if (in_range_q) begin
              valid_d[slot_q] = 1'b0;
            end
          end
          default: ;
        endcase
      end
      StTickWb: begin
        if (sum_q > wm_q) begin
          wm_d = sum_q;
        end
        state_d = StDone;
      end
      StScan: begin
        if (scan_end) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (load_out) begin
          out_vld_d = 1'b1;
          state_d   = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      valid_q   <= '0;
      wm_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      wm_q      <= wm_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= s_axis_tuser_i;
      slot_q     <= start_idx;
      in_range_q <= in_range;
      ticks_q    <= s_axis_tdata_i[fstp_pkg::TaskW +: fstp_pkg::TicksW];
      rd_idx_q   <= start_idx;
      cnt_q      <= '0;
      found_q    <= 1'b0;
    end
    if (state_q == StExec) begin
      sum_q <= rd_data + fstp_pkg::RtW'(ticks_q);
    end
    if (state_q == StScan) begin
      rd_idx_q <= next_idx;
      cnt_q    <= cnt_q + fstp_pkg::IdxW'(1);
      if (take) begin
        found_q <= 1'b1;
        least_q <= rd_data;
        best_q  <= rd_idx_q;
      end
    end
    if (load_out) begin
      out_flag_q <= (op_q == fstp_pkg::OpPick) && found_q;
      out_task_q <= ((op_q == fstp_pkg::OpPick) && found_q) ?
                    fstp_pkg::TaskW'(best_q) : '0;
      out_wm_q   <= wm_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_flag_q;
  assign m_axis_tdata_o  = fstp_pkg::OutDataW'({out_wm_q, out_task_q});

  ap_wm_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wm_q >= $past(wm_q))
    else $error("watermark moved backward");

  ap_pick_is_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && op_q == fstp_pkg::OpPick && found_q) |-> valid_q[best_q])
    else $error("picked slot is not valid");

  ap_tick_wb_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StTickWb) |-> (in_range_q && valid_q[slot_q] && op_q == fstp_pkg::OpTick))
    else $error("tick write-back to an empty slot");

  ap_scan_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |=> (state_q == StScan || state_q == StDone))
    else $error("scan left early");

endmodule
